@@ hdl/svl_pkg.sv @@
// Shared types and constants for the sorted value list.
// Used by svl_cell and sorted_value_list; depends on nothing else.
package svl_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int OUT_W   = 104;

  typedef enum logic [CMD_W-1:0] {
    OP_INSERT = 3'd0,
    OP_RM_MIN = 3'd1,
    OP_RM_MAX = 3'd2,
    OP_RM_VAL = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic eval;
    logic ins;
    logic rm_min;
    logic rm_max;
    logic rm_val;
  } ctl_t;

endpackage

@@ hdl/svl_cell.sv @@
// One cell of the sorted chain: holds a single entry and its valid bit.
// Depends on svl_pkg for the control struct and value width.
module svl_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  svl_pkg::ctl_t                ctl,
  input  logic [svl_pkg::VALUE_W-1:0]  key,
  input  logic [svl_pkg::VALUE_W-1:0]  left_entry,
  input  logic                         left_valid,
  input  logic                         left_past,
  input  logic                         left_eq,
  input  logic [svl_pkg::VALUE_W-1:0]  right_entry,
  input  logic                         right_valid,
  output logic [svl_pkg::VALUE_W-1:0]  entry_o,
  output logic                         valid_o,
  output logic                         past_o,
  output logic                         eq_o,
  output logic                         first_o
);

  logic [svl_pkg::VALUE_W-1:0] entry_r, entry_nxt;
  logic                        valid_r, valid_nxt;
  logic                        past_r, past_nxt;
  logic                        eq_r, eq_nxt;

  // The past flag marks a cell that lies at or beyond the insert position.
  always_comb begin
    past_nxt  = past_r;
    eq_nxt    = eq_r;
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctl.eval) begin
      past_nxt = !valid_r || ($signed(entry_r) > $signed(key));
      eq_nxt   = valid_r && (entry_r == key);
    end
    if (ctl.ins) begin
      if (left_past) begin
        entry_nxt = left_entry;
        valid_nxt = left_valid;
      end else if (past_r) begin
        entry_nxt = key;
        valid_nxt = 1'b1;
      end
    end else if (ctl.rm_min || (ctl.rm_val && (past_r || eq_r))) begin
      entry_nxt = right_entry;
      valid_nxt = right_valid;
    end else if (ctl.rm_max) begin
      valid_nxt = valid_r && right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      past_r  <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      past_r  <= past_nxt;
      eq_r    <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign valid_o = valid_r;
  assign past_o  = past_r;
  assign eq_o    = eq_r;
  assign first_o = eq_r && !left_eq;

endmodule

@@ hdl/sorted_value_list.sv @@
// Sorted value list: a chain of CAPACITY compare-and-shift cells with a controller.
// Depends on svl_pkg and svl_cell.
// Each word has two steps: S_EVAL compares the key in every cell, S_DONE commits.
// A new word is taken in the commit cycle, while the previous word commits.
// The result is registered at the commit; a stalled result holds the commit.
// Synchronous reset empties the list; entry contents are not cleared.
module sorted_value_list #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [svl_pkg::VALUE_W-1:0]  in_tdata,  // value
  input  logic [svl_pkg::CMD_W-1:0]    in_tuser,  // command
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // result_value, has_pred, pred_value, has_succ, succ_value, count, one pad bit
  output logic [svl_pkg::OUT_W-1:0]    out_tdata,
  output logic [svl_pkg::STAT_W-1:0]   out_tuser  // status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = svl_pkg::VALUE_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [svl_pkg::CMD_W-1:0]    cmd_r;
  logic [VW-1:0]                key_r;
  logic [CW-1:0]                occ_r, occ_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [svl_pkg::OUT_W-1:0]    out_data_r, out_data_nxt;
  logic [svl_pkg::STAT_W-1:0]   out_user_r, out_user_nxt;

  svl_pkg::ctl_t ctl;
  logic          accept;
  logic          done_go;
  logic          empty;
  logic          full;

  logic [VW-1:0]       entry_w   [CAPACITY];
  logic [CAPACITY-1:0] valid_w;
  logic [CAPACITY-1:0] past_w;
  logic [CAPACITY-1:0] eq_w;
  logic [CAPACITY-1:0] first_w;
  logic [CAPACITY-1:0] rfirst_w;
  logic [CAPACITY-1:0] lfirst_w;
  logic [CAPACITY-1:0] rvalid_w;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] l_entry, r_entry;
    logic          l_valid, l_past, l_eq;
    if (i == 0) begin : g_head
      assign l_entry     = '0;
      assign l_valid     = 1'b1;
      assign l_past      = 1'b0;
      assign l_eq        = 1'b0;
      assign lfirst_w[i] = 1'b0;
    end else begin : g_body
      assign l_entry     = entry_w[i-1];
      assign l_valid     = valid_w[i-1];
      assign l_past      = past_w[i-1];
      assign l_eq        = eq_w[i-1];
      assign lfirst_w[i] = first_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign r_entry     = '0;
      assign rvalid_w[i] = 1'b0;
      assign rfirst_w[i] = 1'b0;
    end else begin : g_mid
      assign r_entry     = entry_w[i+1];
      assign rvalid_w[i] = valid_w[i+1];
      assign rfirst_w[i] = first_w[i+1];
    end

    svl_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .key         (key_r),
      .left_entry  (l_entry),
      .left_valid  (l_valid),
      .left_past   (l_past),
      .left_eq     (l_eq),
      .right_entry (r_entry),
      .right_valid (rvalid_w[i]),
      .entry_o     (entry_w[i]),
      .valid_o     (valid_w[i]),
      .past_o      (past_w[i]),
      .eq_o        (eq_w[i]),
      .first_o     (first_w[i])
    );
  end

  // Gather the matched entry, its neighbors and the last entry from the chain.
  logic          found, has_pred, has_succ;
  logic [VW-1:0] match_val, pred_val, succ_val, max_val;

  always_comb begin
    found     = 1'b0;
    has_pred  = 1'b0;
    has_succ  = 1'b0;
    match_val = '0;
    pred_val  = '0;
    succ_val  = '0;
    max_val   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found     = found | first_w[i];
      has_pred  = has_pred | rfirst_w[i];
      has_succ  = has_succ | (lfirst_w[i] & valid_w[i]);
      match_val = match_val | (first_w[i] ? entry_w[i] : '0);
      pred_val  = pred_val | (rfirst_w[i] ? entry_w[i] : '0);
      succ_val  = succ_val | ((lfirst_w[i] & valid_w[i]) ? entry_w[i] : '0);
      max_val   = max_val | ((valid_w[i] & ~rvalid_w[i]) ? entry_w[i] : '0);
    end
  end

  assign empty     = (occ_r == '0);
  assign full      = (occ_r == CW'(CAPACITY));
  assign done_go   = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE) || done_go;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    svl_pkg::status_t st;
    logic [VW-1:0]    rv, pv, sv;
    logic             hp, hs;
    st      = svl_pkg::ST_OK;
    rv      = '0;
    pv      = '0;
    sv      = '0;
    hp      = 1'b0;
    hs      = 1'b0;
    occ_nxt = occ_r;
    ctl     = '0;
    ctl.eval = (state_r == S_EVAL);
    unique case (cmd_r)
      svl_pkg::OP_INSERT: begin
        if (full) begin
          st = svl_pkg::ST_FULL;
        end else begin
          rv      = key_r;
          ctl.ins = done_go;
          occ_nxt = occ_r + CW'(1);
        end
      end
      svl_pkg::OP_RM_MIN: begin
        if (empty) begin
          st = svl_pkg::ST_EMPTY;
        end else begin
          rv         = entry_w[0];
          ctl.rm_min = done_go;
          occ_nxt    = occ_r - CW'(1);
        end
      end
      svl_pkg::OP_RM_MAX: begin
        if (empty) begin
          st = svl_pkg::ST_EMPTY;
        end else begin
          rv         = max_val;
          ctl.rm_max = done_go;
          occ_nxt    = occ_r - CW'(1);
        end
      end
      svl_pkg::OP_RM_VAL: begin
        if (empty) begin
          st = svl_pkg::ST_EMPTY;
        end else if (!found) begin
          st = svl_pkg::ST_MISSING;
        end else begin
          rv         = match_val;
          ctl.rm_val = done_go;
          occ_nxt    = occ_r - CW'(1);
        end
      end
      svl_pkg::OP_QUERY: begin
        if (empty) begin
          st = svl_pkg::ST_EMPTY;
        end else if (!found) begin
          st = svl_pkg::ST_MISSING;
        end else begin
          rv = match_val;
          hp = has_pred;
          pv = pred_val;
          hs = has_succ;
          sv = succ_val;
        end
      end
      default: begin
      end
    endcase
    out_user_nxt = st;
    out_data_nxt = {1'b0, svl_pkg::COUNT_W'(occ_nxt), sv, hs, pv, hp, rv};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (done_go) begin
          state_nxt = accept ? S_EVAL : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (done_go) begin
        occ_r <= occ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_tuser;
      key_r <= in_tdata;
    end
    if (done_go) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY))
    else $error("occupancy exceeds capacity");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_w) == int'(occ_r))
    else $error("cell valid bits disagree with occupancy");

  a_eval_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |=> (state_r == S_DONE))
    else $error("compare cycle not followed by commit");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    done_go |=> out_valid_r)
    else $error("commit did not present a result");
`endif

endmodule

@@ dv/tb_sorted_value_list.sv @@
// Self-checking testbench for sorted_value_list: a directed table, then random command phases.
// Each accepted command is run through a behavioral sorted list, and an expected result is queued.
// Depends on svl_pkg and the sorted_value_list RTL.
module tb_sorted_value_list;
  import svl_pkg::*;

  localparam int LIST_DEPTH    = 16;
  localparam int RANDOM_WORDS  = 1525;
  localparam int QUIET_WORDS   = 200;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PRINT_LIMIT   = 60;

  // Command codes that the block treats as no-ops.
  localparam logic [CMD_W-1:0] OP_NOP_5 = 3'd5;
  localparam logic [CMD_W-1:0] OP_NOP_6 = 3'd6;
  localparam logic [CMD_W-1:0] OP_NOP_7 = 3'd7;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   value;
    logic                 has_pred;
    logic [VALUE_W-1:0]   pred;
    logic                 has_succ;
    logic [VALUE_W-1:0]   succ;
    logic [COUNT_W-1:0]   count;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic [VALUE_W-1:0] val;
    logic               typed;
    status_t            st;
    logic [VALUE_W-1:0] rv;
    logic [COUNT_W-1:0] cnt;
  } probe_row_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BLEND, MIX_LOOKUP} mix_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata   = '0;
  logic [CMD_W-1:0]   in_tuser   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic [STAT_W-1:0]  out_tuser;

  logic signed [VALUE_W-1:0] sorted_q[$];
  list_result_t              pending_results[$];
  int                        errors       = 0;
  int                        results_seen = 0;
  int                        cycles       = 0;
  int                        gap_pct      = 0;
  int                        stall_pct    = 0;
  int                        stall_left   = 0;

  // Rows with a typed result can be read straight off the list contents;
  // the rest are checked against the behavioral list.
  probe_row_t probes [25] = '{
    '{OP_RM_MIN, 32'h0000_0000, 1'b1, ST_EMPTY,   32'h0000_0000, 5'd0},
    '{OP_RM_MAX, 32'h0000_0000, 1'b1, ST_EMPTY,   32'h0000_0000, 5'd0},
    '{OP_RM_VAL, 32'h0000_0005, 1'b1, ST_EMPTY,   32'h0000_0000, 5'd0},
    '{OP_QUERY,  32'h0000_0005, 1'b1, ST_EMPTY,   32'h0000_0000, 5'd0},
    '{OP_NOP_5,  32'hffff_ffff, 1'b1, ST_OK,      32'h0000_0000, 5'd0},
    '{OP_INSERT, 32'h7fff_ffff, 1'b1, ST_OK,      32'h7fff_ffff, 5'd1},
    '{OP_INSERT, 32'h8000_0000, 1'b1, ST_OK,      32'h8000_0000, 5'd2},
    '{OP_INSERT, 32'h0000_0000, 1'b1, ST_OK,      32'h0000_0000, 5'd3},
    '{OP_INSERT, 32'h0000_0000, 1'b1, ST_OK,      32'h0000_0000, 5'd4},
    '{OP_INSERT, 32'hffff_ffff, 1'b1, ST_OK,      32'hffff_ffff, 5'd5},
    '{OP_QUERY,  32'h0000_0000, 1'b0, ST_OK,      32'h0000_0000, 5'd0},
    '{OP_QUERY,  32'h7fff_ffff, 1'b0, ST_OK,      32'h0000_0000, 5'd0},
    '{OP_QUERY,  32'h8000_0000, 1'b0, ST_OK,      32'h0000_0000, 5'd0},
    '{OP_QUERY,  32'h0000_3039, 1'b1, ST_MISSING, 32'h0000_0000, 5'd5},
    '{OP_RM_VAL, 32'h0000_3039, 1'b1, ST_MISSING, 32'h0000_0000, 5'd5},
    '{OP_RM_VAL, 32'h0000_0000, 1'b1, ST_OK,      32'h0000_0000, 5'd4},
    '{OP_NOP_6,  32'h5a5a_5a5a, 1'b1, ST_OK,      32'h0000_0000, 5'd4},
    '{OP_NOP_7,  32'ha5a5_a5a5, 1'b1, ST_OK,      32'h0000_0000, 5'd4},
    '{OP_RM_MIN, 32'h1234_5678, 1'b1, ST_OK,      32'h8000_0000, 5'd3},
    '{OP_RM_MAX, 32'h8765_4321, 1'b1, ST_OK,      32'h7fff_ffff, 5'd2},
    '{OP_INSERT, 32'hffff_ffff, 1'b1, ST_OK,      32'hffff_ffff, 5'd3},
    '{OP_QUERY,  32'hffff_ffff, 1'b0, ST_OK,      32'h0000_0000, 5'd0},
    '{OP_RM_VAL, 32'hffff_ffff, 1'b1, ST_OK,      32'hffff_ffff, 5'd2},
    '{OP_RM_MIN, 32'h0000_0000, 1'b1, ST_OK,      32'hffff_ffff, 5'd1},
    '{OP_QUERY,  32'h0000_0000, 1'b0, ST_OK,      32'h0000_0000, 5'd0}
  };

  sorted_value_list #(.CAPACITY(LIST_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sorted_value_list NOT OK");
      $finish;
    end
  end

  function automatic int find_first(logic signed [VALUE_W-1:0] v);
    for (int i = 0; i < sorted_q.size(); i++) begin
      if (sorted_q[i] == v) return i;
    end
    return -1;
  endfunction

  // Applies one command to the behavioral list and returns the result word it yields.
  function automatic list_result_t list_apply(logic [CMD_W-1:0] op,
                                              logic signed [VALUE_W-1:0] v);
    list_result_t r;
    int pos;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (sorted_q.size() >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < sorted_q.size() && sorted_q[pos] <= v) pos++;
          sorted_q.insert(pos, v);
          r.value = v;
        end
      end
      OP_RM_MIN, OP_RM_MAX: begin
        if (sorted_q.size() == 0) r.status = ST_EMPTY;
        else if (op == OP_RM_MIN) r.value = sorted_q.pop_front();
        else r.value = sorted_q.pop_back();
      end
      OP_RM_VAL, OP_QUERY: begin
        pos = find_first(v);
        if (sorted_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (pos < 0) begin
          r.status = ST_MISSING;
        end else begin
          r.value = sorted_q[pos];
          if (op == OP_RM_VAL) begin
            sorted_q.delete(pos);
          end else begin
            if (pos > 0) begin
              r.has_pred = 1'b1;
              r.pred     = sorted_q[pos-1];
            end
            if (pos + 1 < sorted_q.size()) begin
              r.has_succ = 1'b1;
              r.succ     = sorted_q[pos+1];
            end
          end
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(sorted_q.size());
    return r;
  endfunction

  function automatic logic [CMD_W-1:0] pick_op(mix_t mix);
    op_t ops [5] = '{OP_INSERT, OP_RM_MIN, OP_RM_MAX, OP_RM_VAL, OP_QUERY};
    int  w [5];
    int  roll;
    if ($urandom_range(0, 99) < 3) return CMD_W'($urandom_range(OP_NOP_5, OP_NOP_7));
    case (mix)
      MIX_FILL:  w = '{70, 5, 5, 10, 10};
      MIX_DRAIN: w = '{15, 25, 25, 20, 15};
      MIX_BLEND: w = '{30, 15, 15, 20, 20};
      default:   w = '{25, 5, 5, 25, 40};
    endcase
    roll = $urandom_range(0, 99);
    for (int k = 0; k < 5; k++) begin
      if (roll < w[k]) return ops[k];
      roll -= w[k];
    end
    return OP_QUERY;
  endfunction

  // Mostly values already stored or from a narrow band, so that duplicates,
  // hits and near neighbors are common; the rest span the full range.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40 && sorted_q.size() != 0) return sorted_q[$urandom_range(0, sorted_q.size()-1)];
    if (roll < 70) return VALUE_W'($urandom_range(0, 8) - 4);
    if (roll < 80) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h8000_0001;
        default: return 32'h7fff_fffe;
      endcase
    end
    return $urandom();
  endfunction

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    if (errors < PRINT_LIMIT)
      $display("mismatch in %s of result %0d: got %h, expected %h",
               what, results_seen, got, want);
    errors++;
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_cmd(logic [CMD_W-1:0] op, logic [VALUE_W-1:0] v,
                          logic typed, list_result_t want);
    list_result_t r;
    in_tuser  <= op;
    in_tdata  <= v;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    r = list_apply(op, v);
    pending_results.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic idle_burst();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 17)) @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) >= stall_pct) begin
      out_tready <= 1'b1;
    end else begin
      stall_left = $urandom_range(1, 17) - 1;
      out_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    list_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("presence (no result pending)", out_tdata[31:0], '0);
      end else begin
        e = pending_results.pop_front();
        if (out_tuser !== e.status)       report_mismatch("status", out_tuser, e.status);
        if (out_tdata[31:0] !== e.value)  report_mismatch("value", out_tdata[31:0], e.value);
        if (out_tdata[32] !== e.has_pred) report_mismatch("has_pred", out_tdata[32], e.has_pred);
        if (out_tdata[64:33] !== e.pred)  report_mismatch("pred", out_tdata[64:33], e.pred);
        if (out_tdata[65] !== e.has_succ) report_mismatch("has_succ", out_tdata[65], e.has_succ);
        if (out_tdata[97:66] !== e.succ)  report_mismatch("succ", out_tdata[97:66], e.succ);
        if (out_tdata[102:98] !== e.count)
          report_mismatch("count", out_tdata[102:98], e.count);
      end
      results_seen++;
    end
  end

  initial begin
    list_result_t want;
    mix_t         mix;
    int           sent;
    int           run;
    logic         quiet;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    gap_pct   = 20;
    stall_pct = 20;
    foreach (probes[i]) begin
      want        = '0;
      want.status = probes[i].st;
      want.value  = probes[i].rv;
      want.count  = probes[i].cnt;
      send_cmd(probes[i].op, probes[i].val, probes[i].typed, want);
      if ($urandom_range(0, 99) < gap_pct) idle_burst();
    end
    hold_until_drained();

    // The first phase is insert-heavy so that the list fills early and
    // inserts into a full list are seen.
    sent = 0;
    mix  = MIX_FILL;
    run  = 40;
    while (sent < RANDOM_WORDS) begin
      quiet = (sent >= RANDOM_WORDS - QUIET_WORDS);
      if (quiet) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        if ($urandom_range(0, 7) == 0) hold_until_drained();
      end
      for (int k = 0; k < run && sent < RANDOM_WORDS; k++) begin
        send_cmd(pick_op(mix), pick_value(), 1'b0, '0);
        sent++;
        if ($urandom_range(0, 99) < gap_pct) idle_burst();
      end
      mix = mix_t'($urandom_range(0, 3));
      run = $urandom_range(10, 60);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_sorted_value_list OK");
    end else begin
      $display("tb_sorted_value_list NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/svl_pkg.sv
hdl/svl_cell.sv
hdl/sorted_value_list.sv
dv/tb_sorted_value_list.sv
